### src/mat3_pkg.sv
package mat3_pkg;

  // matrix geometry and element widths
  localparam int unsigned DIM    = 3;
  localparam int unsigned CELLS  = DIM * DIM;
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned OUT_W  = 33;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned IDX_W  = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(DIM);

  // operation register codes, bit 1 selects the matrix product
  localparam int unsigned OP_W       = 2;
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam int unsigned OP_MUL_BIT = 1;

  // control that travels with each memory read through the datapath
  typedef struct packed {
    logic valid;  // a read is issued in this slot
    logic mul;    // product term, otherwise element-wise
    logic sub;    // element-wise difference
    logic first;  // first term of a result entry
    logic last;   // last term of a result entry
    logic tail;   // last term of the last entry of the run
  } ctl_t;

endpackage

### src/mat3_if.sv
// input channel: one pair of matrix elements per transaction
interface mat3_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mat3_pkg::ELEM_W-1:0]      a_element;
  logic signed [mat3_pkg::ELEM_W-1:0]      b_element;

  modport source (output valid, a_element, b_element, input ready);
  modport sink   (input valid, a_element, b_element, output ready);
endinterface

// output channel: one result entry per transaction
interface mat3_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mat3_pkg::OUT_W-1:0]       result_value;
  logic                                    last_of_run;

  modport source (output valid, result_value, last_of_run, input ready);
  modport sink   (input valid, result_value, last_of_run, output ready);
endinterface

### src/mat3_mem.sv
module mat3_mem (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [mat3_pkg::IDX_W-1:0]          waddr_i,
  input  logic signed [mat3_pkg::ELEM_W-1:0]  a_wdata_i,
  input  logic signed [mat3_pkg::ELEM_W-1:0]  b_wdata_i,
  input  logic                                re_i,
  input  logic [mat3_pkg::IDX_W-1:0]          a_raddr_i,
  input  logic [mat3_pkg::IDX_W-1:0]          b_raddr_i,
  output logic signed [mat3_pkg::ELEM_W-1:0]  a_rdata_o,
  output logic signed [mat3_pkg::ELEM_W-1:0]  b_rdata_o
);
  import mat3_pkg::*;

  logic signed [ELEM_W-1:0] a_mem [CELLS];
  logic signed [ELEM_W-1:0] b_mem [CELLS];
  logic signed [ELEM_W-1:0] a_rd_q;
  logic signed [ELEM_W-1:0] b_rd_q;

  // matrix a store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      a_mem[waddr_i] <= a_wdata_i;
    end
    if (re_i) begin
      a_rd_q <= a_mem[a_raddr_i];
    end
  end

  // matrix b store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      b_mem[waddr_i] <= b_wdata_i;
    end
    if (re_i) begin
      b_rd_q <= b_mem[b_raddr_i];
    end
  end

  assign a_rdata_o = a_rd_q;
  assign b_rdata_o = b_rd_q;

endmodule

### src/mat3_seq.sv
module mat3_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mat3_pkg::OP_W-1:0]   operation_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic                        we_o,
  output logic [mat3_pkg::IDX_W-1:0]  waddr_o,
  input  logic                        adv_i,
  output mat3_pkg::ctl_t              ctl_o,
  output logic [mat3_pkg::IDX_W-1:0]  a_raddr_o,
  output logic [mat3_pkg::IDX_W-1:0]  b_raddr_o
);
  import mat3_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   load_cnt_q, load_cnt_d;
  logic               mul_q, mul_d;
  logic               sub_q, sub_d;
  logic [CNT_W-1:0]   row_q, row_d;
  logic [CNT_W-1:0]   col_q, col_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic               accept;
  logic               entry_done;
  logic               run_done;

  assign accept     = in_valid_i && in_ready_o;
  assign entry_done = !mul_q || (k_q == CNT_W'(DIM - 1));
  assign run_done   = entry_done && (col_q == CNT_W'(DIM - 1)) &&
                      (row_q == CNT_W'(DIM - 1));

  // load side: write each pair at the running count
  assign in_ready_o = (state_q == ST_LOAD);
  assign we_o       = accept;
  assign waddr_o    = load_cnt_q;

  // read addresses: a at row/k, b at k/col, both at row/col when element-wise
  assign a_raddr_o = IDX_W'(IDX_W'(row_q) * IDX_W'(DIM) + IDX_W'(mul_q ? k_q : col_q));
  assign b_raddr_o = IDX_W'(IDX_W'(mul_q ? k_q : row_q) * IDX_W'(DIM) + IDX_W'(col_q));

  // control for the slot being issued
  always_comb begin
    ctl_o.valid = (state_q == ST_RUN);
    ctl_o.mul   = mul_q;
    ctl_o.sub   = sub_q;
    ctl_o.first = !mul_q || (k_q == '0);
    ctl_o.last  = entry_done;
    ctl_o.tail  = run_done;
  end

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    mul_d      = mul_q;
    sub_d      = sub_q;
    row_d      = row_q;
    col_d      = col_q;
    k_d        = k_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (load_cnt_q == IDX_W'(CELLS - 1)) begin
            load_cnt_d = '0;
            mul_d      = operation_i[OP_MUL_BIT];
            sub_d      = (operation_i == OP_SUB);
            row_d      = '0;
            col_d      = '0;
            k_d        = '0;
            state_d    = ST_RUN;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (adv_i) begin
          if (entry_done) begin
            k_d = '0;
            if (col_q == CNT_W'(DIM - 1)) begin
              col_d = '0;
              if (row_q == CNT_W'(DIM - 1)) begin
                row_d   = '0;
                state_d = ST_LOAD;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else begin
              col_d = col_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      mul_q      <= 1'b0;
      sub_q      <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      mul_q      <= mul_d;
      sub_q      <= sub_d;
      row_q      <= row_d;
      col_q      <= col_d;
      k_q        <= k_d;
    end
  end

endmodule

### src/mat3_dp.sv
module mat3_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mat3_pkg::ctl_t                      ctl_i,
  input  logic signed [mat3_pkg::ELEM_W-1:0]  a_rdata_i,
  input  logic signed [mat3_pkg::ELEM_W-1:0]  b_rdata_i,
  output logic                                adv_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mat3_pkg::OUT_W-1:0]   out_value_o,
  output logic                                out_last_o
);
  import mat3_pkg::*;

  ctl_t                     s1_q;
  ctl_t                     s2_q;
  logic signed [OUT_W-1:0]  term_q;
  logic signed [OUT_W-1:0]  acc_q;
  logic                     out_valid_q;
  logic signed [OUT_W-1:0]  out_value_q;
  logic                     out_last_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [OUT_W-1:0]  a_ext;
  logic signed [OUT_W-1:0]  b_ext;
  logic signed [OUT_W-1:0]  term_d;
  logic signed [OUT_W-1:0]  total;

  // the whole pipe holds while a finished entry waits on a full output register
  assign adv_o = !(s2_q.valid && s2_q.last && out_valid_q && !out_ready_i);

  // term: one product, or the element-wise sum or difference
  assign prod  = a_rdata_i * b_rdata_i;
  assign a_ext = OUT_W'(a_rdata_i);
  assign b_ext = OUT_W'(b_rdata_i);
  always_comb begin
    priority if (s1_q.mul) begin
      term_d = OUT_W'(prod);
    end else if (s1_q.sub) begin
      term_d = a_ext - b_ext;
    end else begin
      term_d = a_ext + b_ext;
    end
  end

  // accumulate, each entry starting from zero
  assign total = (s2_q.first ? '0 : acc_q) + term_q;

  // pipeline control, follows the memory read latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      s1_q <= ctl_i;
      s2_q <= s1_q;
      if (s2_q.valid && s2_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      term_q <= term_d;
      if (s2_q.valid) begin
        acc_q <= total;
      end
      if (s2_q.valid && s2_q.last) begin
        out_value_q <= total;
        out_last_q  <= s2_q.tail;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

### src/matrix_3x3_add_sub_mul.sv
// pipeline: once the ninth pair is taken, each term passes the store read registers,
//   the term register and the accumulator sum into the output register
// throughput: one pair per cycle while loading; add/subtract results take one term
//   per entry and the product takes DIM terms per entry, set by the single multiplier
//   and one read port per store; a full output register stalls the whole pipe
// reset: clears the load count, sequencer, pipeline and operation (add); the
//   element stores hold no reset value and are filled by loading
module matrix_3x3_add_sub_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mat3_pkg::OP_W-1:0]  cfg_wdata_i,
  mat3_in_if.sink                    in_i,
  mat3_out_if.source                 out_o
);
  import mat3_pkg::*;

  logic [OP_W-1:0]          operation_q;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic                     adv;
  ctl_t                     ctl;
  logic [IDX_W-1:0]         a_raddr;
  logic [IDX_W-1:0]         b_raddr;
  logic signed [ELEM_W-1:0] a_rdata;
  logic signed [ELEM_W-1:0] b_rdata;

  // operation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      operation_q <= OP_ADD;
    end else if (cfg_we_i) begin
      operation_q <= cfg_wdata_i;
    end
  end

  // load and read sequencing
  mat3_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (operation_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .we_o        (we),
    .waddr_o     (waddr),
    .adv_i       (adv),
    .ctl_o       (ctl),
    .a_raddr_o   (a_raddr),
    .b_raddr_o   (b_raddr)
  );

  // element stores
  mat3_mem u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .a_wdata_i (in_i.a_element),
    .b_wdata_i (in_i.b_element),
    .re_i      (adv),
    .a_raddr_i (a_raddr),
    .b_raddr_i (b_raddr),
    .a_rdata_o (a_rdata),
    .b_rdata_o (b_rdata)
  );

  // arithmetic, accumulation and output register
  mat3_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .a_rdata_i   (a_rdata),
    .b_rdata_i   (b_rdata),
    .adv_o       (adv),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.result_value),
    .out_last_o  (out_o.last_of_run)
  );

endmodule

### tb/tb_matrix_3x3_add_sub_mul.sv
`timescale 1ns / 1ps

module tb_matrix_3x3_add_sub_mul;
  import mat3_pkg::*;

  // operation codes beyond those in the package
  localparam logic [OP_W-1:0] OP_MUL     = 2'd2;
  localparam logic [OP_W-1:0] OP_MUL_ALT = 2'd3;

  localparam int unsigned IDLE_PCT       = 17;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_RUNS    = 9;

  typedef logic signed [ELEM_W-1:0] matrix_t [CELLS];

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } entry_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [OP_W-1:0] cfg_wdata;

  mat3_in_if  in_if ();
  mat3_out_if out_if ();

  matrix_3x3_add_sub_mul DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // shadow copy of the block state
  matrix_t         a_mat;
  matrix_t         b_mat;
  int unsigned     pairs_loaded;
  logic [OP_W-1:0] op_shadow;
  entry_t          pending_entries [$];

  int unsigned fail_count;
  int unsigned stall_cycles;
  int unsigned hold_req;
  bit          src_idle_en;
  bit          snk_idle_en;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // store one pair; on the last pair of a matrix, queue the nine result entries
  task automatic absorb_pair(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b);
    entry_t      e;
    longint      acc;
    int unsigned r;
    int unsigned c;
    int unsigned k;
    a_mat[pairs_loaded] = a;
    b_mat[pairs_loaded] = b;
    pairs_loaded++;
    if (pairs_loaded == CELLS) begin
      pairs_loaded = 0;
      for (r = 0; r < DIM; r++) begin
        for (c = 0; c < DIM; c++) begin
          if (op_shadow[OP_MUL_BIT]) begin
            acc = 0;
            for (k = 0; k < DIM; k++) begin
              acc += longint'(a_mat[r*DIM+k]) * longint'(b_mat[k*DIM+c]);
            end
          end else if (op_shadow == OP_SUB) begin
            acc = longint'(a_mat[r*DIM+c]) - longint'(b_mat[r*DIM+c]);
          end else begin
            acc = longint'(a_mat[r*DIM+c]) + longint'(b_mat[r*DIM+c]);
          end
          e.value = acc[OUT_W-1:0];
          e.last  = (r*DIM + c == CELLS - 1);
          pending_entries.push_back(e);
        end
      end
    end
  endtask

  // offer one pair, with a random gap ahead of it, and wait for the transaction
  task automatic send_pair(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b);
    while (src_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.a_element <= a;
    in_if.b_element <= b;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_pair(a, b);
  endtask

  task automatic send_matrix(input matrix_t av, input matrix_t bv,
                             input int unsigned first, input int unsigned count);
    int unsigned i;
    for (i = first; i < first + count; i++) begin
      send_pair(av[i], bv[i]);
    end
  endtask

  // extremes and small values half of the time, the rest full range
  function automatic logic signed [ELEM_W-1:0] pick_elem();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 2) begin
      case ($urandom_range(4))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sh0000;
        3: return 16'shffff;
        default: return 16'sh0001;
      endcase
    end else if (sel < 5) begin
      return ELEM_W'($signed($urandom_range(31)) - 16);
    end else begin
      return ELEM_W'($urandom);
    end
  endfunction

  task automatic send_random_matrix();
    matrix_t     av;
    matrix_t     bv;
    int unsigned i;
    for (i = 0; i < CELLS; i++) begin
      av[i] = pick_elem();
      bv[i] = pick_elem();
    end
    send_matrix(av, bv, 0, CELLS);
  endtask

  // stop offering and wait until every result is out and the pipeline is empty
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_operation(input logic [OP_W-1:0] op);
    cfg_we    <= 1'b1;
    cfg_wdata <= op;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    op_shadow = op;
  endtask

  // reset value selects add
  task automatic test_default_add();
    matrix_t av;
    matrix_t bv;
    av = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0000,
           16'shffff, 16'sh0001, 16'sh5555, 16'shaaaa};
    bv = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000,
           16'shffff, 16'shffff, 16'shaaaa, 16'sh5555};
    send_matrix(av, bv, 0, CELLS);
    wait_drained();
  endtask

  task automatic test_sub_extremes();
    matrix_t av;
    matrix_t bv;
    av = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000,
           16'shffff, 16'sh0001, 16'sh5555, 16'shaaaa};
    bv = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
           16'sh0001, 16'shffff, 16'shaaaa, 16'sh5555};
    write_operation(OP_SUB);
    send_matrix(av, bv, 0, CELLS);
    wait_drained();
  endtask

  // operation switches from subtract to product partway through loading;
  // the value held at the last pair decides
  task automatic test_mul_midload_switch();
    matrix_t av;
    matrix_t bv;
    av = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
           16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0001};
    bv = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh8000, 16'sh7fff,
           16'shffff, 16'sh8000, 16'sh7fff, 16'sh0001};
    send_matrix(av, bv, 0, 4);
    wait_drained();
    write_operation(OP_MUL);
    send_matrix(av, bv, 4, CELLS - 4);
    wait_drained();
  endtask

  // the spare code also selects the product
  task automatic test_unused_code();
    write_operation(OP_MUL_ALT);
    send_random_matrix();
    wait_drained();
  endtask

  task automatic test_random_runs();
    int unsigned run;
    // back-to-back products with no idling on either side
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    write_operation(OP_MUL);
    for (run = 0; run < 3; run++) begin
      send_random_matrix();
    end
    wait_drained();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    write_operation(OP_ADD);
    for (run = 3; run < RANDOM_RUNS; run++) begin
      if ($urandom_range(1) == 1) begin
        wait_drained();
        write_operation(OP_W'($urandom_range(3)));
      end
      send_random_matrix();
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    write_operation(OP_MUL);
    hold_req = HOLD_CYCLES;
    send_random_matrix();
    send_random_matrix();
    wait_drained();
    src_idle_en = 1'b1;
  endtask

  // receiver: checks each result transaction and drives ready
  initial begin
    entry_t      exp_e;
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_entries.size() == 0) begin
          $error("unexpected result: result_value %0d last_of_run %0b",
                 out_if.result_value, out_if.last_of_run);
          fail_count++;
        end else begin
          exp_e = pending_entries.pop_front();
          if (out_if.result_value !== exp_e.value) begin
            $error("result_value: expected %0d, actual %0d", exp_e.value, out_if.result_value);
            fail_count++;
          end
          if (out_if.last_of_run !== exp_e.last) begin
            $error("last_of_run: expected %0b, actual %0b", exp_e.last, out_if.last_of_run);
            fail_count++;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (snk_idle_en) begin
        out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    fail_count      = 0;
    hold_req        = 0;
    pairs_loaded    = 0;
    op_shadow       = OP_ADD;
    src_idle_en     = 1'b1;
    snk_idle_en     = 1'b1;
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= OP_ADD;
    in_if.valid     <= 1'b0;
    in_if.a_element <= '0;
    in_if.b_element <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_add();
    test_sub_extremes();
    test_mul_midload_switch();
    test_unused_code();
    test_random_runs();
    test_backpressure();

    wait_drained();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
